// ===== src/ps2mct_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Shared types, widths, codes and reset values of the cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned BTN_W     = 3;
  localparam int unsigned DX_W      = 9;
  localparam int unsigned DY_W      = 10;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] ACK_BYTE  = 8'hFA;
  localparam logic [BYTE_W-1:0] HDR_MASK  = 8'hC8;
  localparam logic [BYTE_W-1:0] HDR_MATCH = 8'h08;
  localparam int unsigned       XSIGN_BIT = 4;
  localparam int unsigned       YSIGN_BIT = 5;

  localparam logic [POS_W-1:0] SCREEN_W_RST = 12'd640;
  localparam logic [POS_W-1:0] SCREEN_H_RST = 12'd480;
  localparam logic [POS_W-1:0] POS_X_RST    = 12'd320;
  localparam logic [POS_W-1:0] POS_Y_RST    = 12'd240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_WAIT_ACK = 2'd0,
    PH_FIRST    = 2'd1,
    PH_SECOND   = 2'd2,
    PH_THIRD    = 2'd3
  } phase_t;

endpackage

// ===== src/ps2mct_if.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker channel interfaces
// Valid/ready channels for received bytes, packet results and register writes.
// ----------------------------------------------------------------------------
interface ps2mct_byte_if;
  logic                            valid;
  logic                            ready;
  logic [ps2mct_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ps2mct_result_if;
  logic                                valid;
  logic                                ready;
  logic [ps2mct_pkg::BTN_W-1:0]        buttons;
  logic signed [ps2mct_pkg::DX_W-1:0]  delta_x;
  logic signed [ps2mct_pkg::DY_W-1:0]  delta_y;
  logic [ps2mct_pkg::POS_W-1:0]        cursor_x;
  logic [ps2mct_pkg::POS_W-1:0]        cursor_y;

  modport source (output valid, output buttons, output delta_x, output delta_y,
                  output cursor_x, output cursor_y, input ready);
  modport sink (input valid, input buttons, input delta_x, input delta_y,
                input cursor_x, input cursor_y, output ready);
endinterface

interface ps2mct_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ps2mct_pkg::CFG_IDX_W-1:0]   index;
  logic [ps2mct_pkg::POS_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/ps2mct_axis_clamp.sv =====
// ----------------------------------------------------------------------------
// Cursor axis update
// Adds a signed movement to one cursor coordinate and clamps to 0..limit.
// ----------------------------------------------------------------------------
module ps2mct_axis_clamp (
  input  logic [ps2mct_pkg::POS_W-1:0]       pos_i,
  input  logic signed [ps2mct_pkg::DY_W-1:0] delta_i,
  input  logic [ps2mct_pkg::POS_W-1:0]       limit_i,
  output logic [ps2mct_pkg::POS_W-1:0]       pos_o
);

  logic [ps2mct_pkg::POS_W+1:0] sum;

  assign sum = {2'b00, pos_i} + {{4{delta_i[ps2mct_pkg::DY_W-1]}}, delta_i};

  always_comb begin
    if (sum[ps2mct_pkg::POS_W+1]) begin
      pos_o = '0;
    end else if (sum[ps2mct_pkg::POS_W:0] > {1'b0, limit_i}) begin
      pos_o = limit_i;
    end else begin
      pos_o = sum[ps2mct_pkg::POS_W-1:0];
    end
  end

endmodule

// ===== src/ps2_mouse_packet_cursor_tracker.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker
// Frames three-byte mouse packets after the acknowledge byte and tracks a
// clamped cursor position.
// ----------------------------------------------------------------------------
// The third byte passes the byte register, then the result register.
// Throughput: one byte per cycle; the byte register stalls only while a
// result waits in the output register.
// Reset: waits for the acknowledge byte, screen 640 x 480, cursor at 320, 240.
// Configuration writes are taken in every cycle.
module ps2_mouse_packet_cursor_tracker (
  input  logic                    clk,
  input  logic                    rst_n,
  ps2mct_byte_if.sink             in_ch,
  ps2mct_result_if.source         out_ch,
  ps2mct_cfg_if.sink              cfg_ch
);

  logic                                 in_valid_r;
  logic [ps2mct_pkg::BYTE_W-1:0]        in_byte_r;
  logic                                 advance;
  logic                                 fire;

  ps2mct_pkg::phase_t                   phase_r;
  ps2mct_pkg::phase_t                   phase_nxt;
  logic                                 load_first;
  logic                                 load_second;
  logic                                 emit;

  logic [ps2mct_pkg::BYTE_W-1:0]        first_byte_r;
  logic [ps2mct_pkg::BYTE_W-1:0]        second_byte_r;
  logic [ps2mct_pkg::POS_W-1:0]         screen_w_r;
  logic [ps2mct_pkg::POS_W-1:0]         screen_h_r;
  logic [ps2mct_pkg::POS_W-1:0]         pos_x_r;
  logic [ps2mct_pkg::POS_W-1:0]         pos_y_r;
  logic [ps2mct_pkg::POS_W-1:0]         pos_x_nxt;
  logic [ps2mct_pkg::POS_W-1:0]         pos_y_nxt;
  logic [ps2mct_pkg::POS_W-1:0]         clamp_x;
  logic [ps2mct_pkg::POS_W-1:0]         clamp_y;

  logic signed [ps2mct_pkg::DX_W-1:0]   dx;
  logic signed [ps2mct_pkg::DX_W-1:0]   dy_raw;
  logic signed [ps2mct_pkg::DY_W-1:0]   dx_ext;
  logic signed [ps2mct_pkg::DY_W-1:0]   dy;
  logic                                 moving;

  logic                                 out_valid_r;
  logic [ps2mct_pkg::BTN_W-1:0]         out_buttons_r;
  logic signed [ps2mct_pkg::DX_W-1:0]   out_dx_r;
  logic signed [ps2mct_pkg::DY_W-1:0]   out_dy_r;
  logic [ps2mct_pkg::POS_W-1:0]         out_x_r;
  logic [ps2mct_pkg::POS_W-1:0]         out_y_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= ps2mct_pkg::SCREEN_W_RST;
      screen_h_r <= ps2mct_pkg::SCREEN_H_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ps2mct_pkg::REG_SCREEN_WIDTH:  screen_w_r <= cfg_ch.data;
        ps2mct_pkg::REG_SCREEN_HEIGHT: screen_h_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;
  assign fire        = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      ps2mct_pkg::PH_WAIT_ACK: begin
        if (in_byte_r == ps2mct_pkg::ACK_BYTE) begin
          phase_nxt = ps2mct_pkg::PH_FIRST;
        end
      end
      ps2mct_pkg::PH_FIRST: begin
        if ((in_byte_r & ps2mct_pkg::HDR_MASK) == ps2mct_pkg::HDR_MATCH) begin
          phase_nxt = ps2mct_pkg::PH_SECOND;
        end
      end
      ps2mct_pkg::PH_SECOND: phase_nxt = ps2mct_pkg::PH_THIRD;
      ps2mct_pkg::PH_THIRD:  phase_nxt = ps2mct_pkg::PH_FIRST;
      default:               phase_nxt = ps2mct_pkg::PH_WAIT_ACK;
    endcase
  end

  always_comb begin
    load_first  = 1'b0;
    load_second = 1'b0;
    emit        = 1'b0;
    case (phase_r)
      ps2mct_pkg::PH_FIRST:  load_first = (phase_nxt == ps2mct_pkg::PH_SECOND);
      ps2mct_pkg::PH_SECOND: load_second = 1'b1;
      ps2mct_pkg::PH_THIRD:  emit = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ps2mct_pkg::PH_WAIT_ACK;
    end else if (fire) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && load_first) begin
      first_byte_r <= in_byte_r;
    end
    if (fire && load_second) begin
      second_byte_r <= in_byte_r;
    end
  end

  assign dx     = {first_byte_r[ps2mct_pkg::XSIGN_BIT], second_byte_r};
  assign dy_raw = {first_byte_r[ps2mct_pkg::YSIGN_BIT], in_byte_r};
  assign dx_ext = {dx[ps2mct_pkg::DX_W-1], dx};
  assign dy     = -{dy_raw[ps2mct_pkg::DX_W-1], dy_raw};
  assign moving = (dx != '0) || (dy != '0);

  ps2mct_axis_clamp u_clamp_x (
    .pos_i   (pos_x_r),
    .delta_i (dx_ext),
    .limit_i (screen_w_r),
    .pos_o   (clamp_x)
  );

  ps2mct_axis_clamp u_clamp_y (
    .pos_i   (pos_y_r),
    .delta_i (dy),
    .limit_i (screen_h_r),
    .pos_o   (clamp_y)
  );

  assign pos_x_nxt = moving ? clamp_x : pos_x_r;
  assign pos_y_nxt = moving ? clamp_y : pos_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= ps2mct_pkg::POS_X_RST;
      pos_y_r <= ps2mct_pkg::POS_Y_RST;
    end else if (fire && emit) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_buttons_r <= first_byte_r[ps2mct_pkg::BTN_W-1:0];
      out_dx_r      <= dx;
      out_dy_r      <= dy;
      out_x_r       <= pos_x_nxt;
      out_y_r       <= pos_y_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.buttons  = out_buttons_r;
  assign out_ch.delta_x  = out_dx_r;
  assign out_ch.delta_y  = out_dy_r;
  assign out_ch.cursor_x = out_x_r;
  assign out_ch.cursor_y = out_y_r;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker testbench
// Feeds mouse bytes around the acknowledge byte, directed packets and random
// packet streams with noise under several screen sizes. Every packet result
// is compared field by field to fixed values or a cycle-free cursor tracker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int N_DIRECTED     = 24;
  localparam int N_PHASES       = 8;
  localparam int PHASE_BYTES    = 200;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [ps2mct_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [ps2mct_pkg::BTN_W-1:0]        buttons;
    logic signed [ps2mct_pkg::DX_W-1:0]  delta_x;
    logic signed [ps2mct_pkg::DY_W-1:0]  delta_y;
    logic [ps2mct_pkg::POS_W-1:0]        cursor_x;
    logic [ps2mct_pkg::POS_W-1:0]        cursor_y;
  } packet_t;

  typedef struct {
    logic [ps2mct_pkg::BYTE_W-1:0] b;
    bit                            fixed;
    packet_t                       pkt;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ps2mct_byte_if   in_if();
  ps2mct_result_if out_if();
  ps2mct_cfg_if    cfg_if();

  ps2_mouse_packet_cursor_tracker uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always #2 clk = ~clk;

  ps2mct_pkg::phase_t                trk_phase = ps2mct_pkg::PH_WAIT_ACK;
  logic [ps2mct_pkg::BYTE_W-1:0]     hdr_byte  = '0;
  logic [ps2mct_pkg::BYTE_W-1:0]     dx_byte   = '0;
  logic [ps2mct_pkg::POS_W-1:0]      cur_x     = ps2mct_pkg::POS_X_RST;
  logic [ps2mct_pkg::POS_W-1:0]      cur_y     = ps2mct_pkg::POS_Y_RST;
  logic [ps2mct_pkg::POS_W-1:0]      scr_w     = ps2mct_pkg::SCREEN_W_RST;
  logic [ps2mct_pkg::POS_W-1:0]      scr_h     = ps2mct_pkg::SCREEN_H_RST;

  packet_t pending_pkts[$];
  int      err_cnt      = 0;
  int      bytes_taken  = 0;
  int      pkts_checked = 0;
  int      cfg_writes   = 0;
  int      stall_cycles = 0;
  bit      idle_on      = 1'b1;
  bit      hold_req     = 1'b0;
  bit      hold_done    = 1'b0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{8'h08, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFA, 1'b0, '0},
    '{8'hFA, 1'b0, '0},
    '{8'hC8, 1'b0, '0},
    '{8'hF7, 1'b0, '0},
    '{8'h08, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{3'd0, 9'sd0, 10'sd0, 12'd320, 12'd240}},
    '{8'h0F, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b1, '{3'd7, 9'sd255, -10'sd255, 12'd575, 12'd0}},
    '{8'h38, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{3'd0, 9'h100, 10'sd256, 12'd319, 12'd256}},
    '{8'h2A, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h0C, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h08, 1'b0, '0},
    '{8'hFA, 1'b0, '0},
    '{8'hFA, 1'b0, '0}
  };

  function automatic logic [ps2mct_pkg::POS_W-1:0] clamp_pos(
    input logic [ps2mct_pkg::POS_W-1:0] p, input int d,
    input logic [ps2mct_pkg::POS_W-1:0] lim);
    int v;
    v = int'(p) + d;
    if (v < 0) return '0;
    if (v > int'(lim)) return lim;
    return v[ps2mct_pkg::POS_W-1:0];
  endfunction

  function automatic bit track_byte(input logic [ps2mct_pkg::BYTE_W-1:0] b,
                                    output packet_t pkt);
    int dx;
    int dy;
    pkt = '0;
    case (trk_phase)
      ps2mct_pkg::PH_WAIT_ACK: begin
        if (b == ps2mct_pkg::ACK_BYTE) trk_phase = ps2mct_pkg::PH_FIRST;
        return 1'b0;
      end
      ps2mct_pkg::PH_FIRST: begin
        if ((b & ps2mct_pkg::HDR_MASK) == ps2mct_pkg::HDR_MATCH) begin
          hdr_byte  = b;
          trk_phase = ps2mct_pkg::PH_SECOND;
        end
        return 1'b0;
      end
      ps2mct_pkg::PH_SECOND: begin
        dx_byte   = b;
        trk_phase = ps2mct_pkg::PH_THIRD;
        return 1'b0;
      end
      default: ;
    endcase
    trk_phase = ps2mct_pkg::PH_FIRST;
    dx = int'(dx_byte) - (hdr_byte[ps2mct_pkg::XSIGN_BIT] ? 256 : 0);
    dy = (hdr_byte[ps2mct_pkg::YSIGN_BIT] ? 256 : 0) - int'(b);
    if (dx != 0 || dy != 0) begin
      cur_x = clamp_pos(cur_x, dx, scr_w);
      cur_y = clamp_pos(cur_y, dy, scr_h);
    end
    pkt.buttons  = hdr_byte[ps2mct_pkg::BTN_W-1:0];
    pkt.delta_x  = dx[ps2mct_pkg::DX_W-1:0];
    pkt.delta_y  = dy[ps2mct_pkg::DY_W-1:0];
    pkt.cursor_x = cur_x;
    pkt.cursor_y = cur_y;
    return 1'b1;
  endfunction

  task automatic report(input string msg);
    $display("[tb] mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_packet();
    packet_t want;
    if (pending_pkts.size() == 0) begin
      report("packet result with no packet pending");
      return;
    end
    want = pending_pkts.pop_front();
    pkts_checked++;
    if (out_if.buttons !== want.buttons)
      report($sformatf("buttons got %0d want %0d", out_if.buttons, want.buttons));
    if (out_if.delta_x !== want.delta_x)
      report($sformatf("delta_x got %0d want %0d", out_if.delta_x, want.delta_x));
    if (out_if.delta_y !== want.delta_y)
      report($sformatf("delta_y got %0d want %0d", out_if.delta_y, want.delta_y));
    if (out_if.cursor_x !== want.cursor_x)
      report($sformatf("cursor_x got %0d want %0d", out_if.cursor_x, want.cursor_x));
    if (out_if.cursor_y !== want.cursor_y)
      report($sformatf("cursor_y got %0d want %0d", out_if.cursor_y, want.cursor_y));
  endtask

  task automatic put_byte(input logic [ps2mct_pkg::BYTE_W-1:0] b, input bit fixed,
                          input packet_t fixed_pkt);
    packet_t pkt;
    bit      taken;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do begin
      @(negedge clk);
      taken = (in_if.ready === 1'b1);
      @(posedge clk);
    end while (!taken);
    bytes_taken++;
    if (track_byte(b, pkt)) pending_pkts.push_back(fixed ? fixed_pkt : pkt);
  endtask

  task automatic write_reg(input logic [ps2mct_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ps2mct_pkg::POS_W-1:0] val);
    bit taken;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do begin
      @(negedge clk);
      taken = (cfg_if.ready === 1'b1);
      @(posedge clk);
    end while (!taken);
    cfg_writes++;
    case (idx)
      ps2mct_pkg::REG_SCREEN_WIDTH:  scr_w = val;
      ps2mct_pkg::REG_SCREEN_HEIGHT: scr_h = val;
      default: ;
    endcase
  endtask

  task automatic send_random(input int budget);
    logic [ps2mct_pkg::BYTE_W-1:0] hdr;
    logic [ps2mct_pkg::BYTE_W-1:0] b1;
    logic [ps2mct_pkg::BYTE_W-1:0] b2;
    int                            sent;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        put_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        hdr      = 8'($urandom_range(0, 255));
        hdr[7:6] = 2'b00;
        hdr[3]   = 1'b1;
        b1       = 8'($urandom_range(0, 255));
        b2       = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0) begin
          hdr[5:4] = 2'b00;
          b1       = '0;
          b2       = '0;
        end
        put_byte(hdr, 1'b0, '0);
        put_byte(b1, 1'b0, '0);
        put_byte(b2, 1'b0, '0);
        sent += 3;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_pkts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) check_packet();
  end

  always @(negedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[ps2_mouse_packet_cursor_tracker] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.rx_byte <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= ps2mct_pkg::REG_SCREEN_WIDTH;
    cfg_if.data   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      put_byte(directed_rows[i].b, directed_rows[i].fixed, directed_rows[i].pkt);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      in_if.valid <= 1'b0;
      wait_drained();
      case (ph)
        0: begin
          write_reg(ps2mct_pkg::REG_SCREEN_WIDTH, 12'd4095);
          write_reg(ps2mct_pkg::REG_SCREEN_HEIGHT, 12'd4095);
        end
        1: begin
          write_reg(ps2mct_pkg::REG_SCREEN_WIDTH, 12'd1);
          write_reg(ps2mct_pkg::REG_SCREEN_HEIGHT, 12'd1);
        end
        2: begin
          write_reg(ps2mct_pkg::REG_SCREEN_WIDTH, 12'd0);
          write_reg(ps2mct_pkg::REG_SCREEN_HEIGHT, 12'd0);
        end
        3: begin
          write_reg(ps2mct_pkg::REG_SCREEN_WIDTH, 12'd100);
          write_reg(REG_SPARE, 12'd4095);
          write_reg(ps2mct_pkg::REG_SCREEN_HEIGHT, 12'd2000);
        end
        N_PHASES - 1: begin
          write_reg(ps2mct_pkg::REG_SCREEN_WIDTH, ps2mct_pkg::SCREEN_W_RST);
          write_reg(ps2mct_pkg::REG_SCREEN_HEIGHT, ps2mct_pkg::SCREEN_H_RST);
        end
        default: begin
          write_reg(ps2mct_pkg::REG_SCREEN_WIDTH, 12'($urandom_range(1, 4095)));
          write_reg(ps2mct_pkg::REG_SCREEN_HEIGHT, 12'($urandom_range(1, 4095)));
        end
      endcase
      cfg_if.valid <= 1'b0;
      idle_on = (ph == N_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (ph == 4) hold_req = 1'b1;
      send_random(PHASE_BYTES);
    end

    in_if.valid <= 1'b0;
    wait_drained();

    $display("Run covered %0d bytes and %0d packet results, including bytes before the",
             bytes_taken, pkts_checked);
    $display("acknowledge, rejected headers and %0d register writes down to size 0.",
             cfg_writes);
    if (err_cnt == 0) begin
      $display("[ps2_mouse_packet_cursor_tracker] OK");
    end else begin
      $display("[ps2_mouse_packet_cursor_tracker] ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/ps2mct_pkg.sv
src/ps2mct_if.sv
src/ps2mct_axis_clamp.sv
src/ps2_mouse_packet_cursor_tracker.sv
test/tb_top.sv
